@@ rtl/core/stoosc_pkg.sv @@
// Shared constants and types for the sine tone oscillator.
`default_nettype none

package stoosc_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int FREQ_W  = 24;
  localparam int AMP_W   = 16;
  localparam int SCALE_W = 22;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(97392);

  localparam int QUARTER_N = 1 << TABLE_ADDR_BITS;
  localparam int TIDX_W    = TABLE_ADDR_BITS + 1;
  // table values reach 32768 at a quarter cycle
  localparam int SINE_W    = 17;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

  typedef logic [Q_LVL_W-1:0] qlvl_t;

  typedef struct packed {
    logic [TIDX_W-1:0]       tidx;
    logic                    neg;
    logic signed [AMP_W-1:0] amp;
  } qent_t;

endpackage

`default_nettype wire

@@ rtl/core/stoosc_front.sv @@
// Front end: phase step multiply, phase accumulator, table address and quadrant.
`default_nettype none

module stoosc_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [stoosc_pkg::SCALE_W-1:0]         cfg_wr_data,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [stoosc_pkg::FREQ_W-1:0]          frequency_q8,
  input  logic signed [stoosc_pkg::AMP_W-1:0]    amplitude_q15,
  input  stoosc_pkg::qlvl_t                      q_level,
  output logic                                   q_push,
  output stoosc_pkg::qent_t                      q_wdata
);
  import stoosc_pkg::*;

  localparam int PROD_W = FREQ_W + SCALE_W;
  localparam int SH_L   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SH_R   = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int INC_W  = PROD_W - 8 + 1;
  localparam int SHW    = INC_W + SH_L;

  logic [SCALE_W-1:0]      scale;
  logic [PHASE_BITS-1:0]   phase;
  logic [PHASE_BITS-1:0]   phase_next;
  logic                    s1_valid;
  logic [PROD_W-1:0]       prod;
  logic signed [AMP_W-1:0] s1_amp;
  logic                    accept;
  logic [INC_W-1:0]        inc32;
  logic [SHW-1:0]          inc_sh;
  logic [1:0]              quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [Q_LVL_W:0]        committed;

  assign committed = (Q_LVL_W+1)'(q_level) + (Q_LVL_W+1)'(s1_valid);
  assign req_stall = committed >= (Q_LVL_W+1)'(Q_DEPTH);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod   <= PROD_W'(frequency_q8) * PROD_W'(scale);
      s1_amp <= amplitude_q15;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (s1_valid) begin
      phase <= phase_next;
    end
  end

  // round half up of the Q8 product, then align to the accumulator width
  always_comb begin
    inc32      = INC_W'(prod[PROD_W-1:8]) + INC_W'(prod[7]);
    inc_sh     = (SHW'(inc32) << SH_L) >> SH_R;
    phase_next = phase + PHASE_BITS'(inc_sh);
    quad       = phase_next[PHASE_BITS-1 -: 2];
    idx        = phase_next[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    q_wdata.tidx = quad[0] ? (TIDX_W'(QUARTER_N) - {1'b0, idx}) : {1'b0, idx};
    q_wdata.neg  = quad[1];
    q_wdata.amp  = s1_amp;
  end

  assign q_push = s1_valid;

endmodule

`default_nettype wire

@@ rtl/core/stoosc_fifo.sv @@
// Short queue between front and back end.
`default_nettype none

module stoosc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stoosc_pkg::qent_t wdata,
  input  logic              pop,
  output stoosc_pkg::qent_t rdata,
  output stoosc_pkg::qlvl_t level,
  output logic              empty
);
  import stoosc_pkg::*;

  qent_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      level <= level + Q_LVL_W'(push) - Q_LVL_W'(pop);
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (level == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> level != Q_LVL_W'(Q_DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(push) && !$past(pop) |-> level == $past(level) + Q_LVL_W'(1))
    else $error("queue level lost a push");
`endif

endmodule

`default_nettype wire

@@ rtl/core/stoosc_back.sv @@
// Back end: quarter-wave table, amplitude multiply, rounding and saturation.
`default_nettype none

module stoosc_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  input  stoosc_pkg::qent_t                        q_rdata,
  output logic                                     q_pop,
  output logic                                     smp_valid,
  input  logic                                     smp_stall,
  output logic signed [stoosc_pkg::SAMPLE_BITS-1:0] sample
);
  import stoosc_pkg::*;

  typedef logic [SINE_W-1:0] quarter_tab_t [QUARTER_N+1];

  localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  // round(sin(pi/2 * j/N) * 32768) from a Q30 Taylor series
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t   tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          v;
    for (int j = 0; j <= QUARTER_N; j++) begin
      x    = (HALF_PI_Q32 * longint'(j) + (64'd1 << (TABLE_ADDR_BITS + 1)))
             >> (TABLE_ADDR_BITS + 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc + 16384) >>> 15;
      if (v > 32768) begin
        v = 32768;
      end
      tab[j] = SINE_W'(v);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER = build_quarter();

  localparam int SINE_SW = SINE_W + 1;
  localparam int PRD_W   = AMP_W + SINE_SW;
  localparam int SH      = 31 - SAMPLE_BITS;
  localparam logic signed [PRD_W-1:0] HALF_LSB = PRD_W'(1 << (SH - 1));
  localparam logic signed [PRD_W-1:0] LIM_P    = PRD_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PRD_W-1:0] LIM_N    = -LIM_P;

  logic                      adv;
  logic                      v1;
  logic                      v2;
  logic [SINE_W-1:0]         mag1;
  logic                      neg1;
  logic signed [AMP_W-1:0]   amp1;
  logic signed [SINE_SW-1:0] sine1;
  logic signed [PRD_W-1:0]   prod2;
  logic signed [PRD_W-1:0]   rnd;
  logic signed [PRD_W-1:0]   sat;

  assign adv   = !smp_valid || !smp_stall;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      smp_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_pop;
      v2        <= v1;
      smp_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1 <= QUARTER[q_rdata.tidx];
      neg1 <= q_rdata.neg;
      amp1 <= q_rdata.amp;
    end
  end

  assign sine1 = neg1 ? -$signed({1'b0, mag1}) : $signed({1'b0, mag1});

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2 <= PRD_W'(amp1) * PRD_W'(sine1);
    end
  end

  always_comb begin
    rnd = (prod2 + HALF_LSB) >>> SH;
    if (rnd > LIM_P) begin
      sat = LIM_P;
    end else if (rnd < LIM_N) begin
      sat = LIM_N;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample <= SAMPLE_BITS'(sat);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sine_tone_oscillator.sv @@
// Top level of the phase-accumulator sine tone oscillator.
//
//   channel   dir  handshake             payload
//   request   in   req_valid/req_stall   frequency_q8, amplitude_q15
//   sample    out  smp_valid/smp_stall   sample
//   config    in   cfg_wr_en             cfg_wr_data (phase_scale)
//
// One transaction per cycle sustained while smp_stall is low; a request is
// registered by multiply, phase add, table read, amplitude multiply and output
// register stages. The phase add is one adder stage, so consecutive requests
// chain without gaps. Reset clears the phase to zero, loads phase_scale with
// 97392, empties the queue. A stalled sample holds the back end; the front
// raises req_stall when the queue plus the multiply stage hold four entries.
`default_nettype none

module sine_tone_oscillator (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_wr_en,
  input  logic [stoosc_pkg::SCALE_W-1:0]            cfg_wr_data,
  input  logic                                      req_valid,
  output logic                                      req_stall,
  input  logic [stoosc_pkg::FREQ_W-1:0]             frequency_q8,
  input  logic signed [stoosc_pkg::AMP_W-1:0]       amplitude_q15,
  output logic                                      smp_valid,
  input  logic                                      smp_stall,
  output logic signed [stoosc_pkg::SAMPLE_BITS-1:0] sample
);
  import stoosc_pkg::*;

  qent_t q_wdata;
  qent_t q_rdata;
  qlvl_t q_level;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;

  stoosc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .frequency_q8  (frequency_q8),
    .amplitude_q15 (amplitude_q15),
    .q_level       (q_level),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  stoosc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .level (q_level),
    .empty (q_empty)
  );

  stoosc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .sample    (sample)
  );

endmodule

`default_nettype wire
